@@ src/dvf_pkg.sv @@
// shared types and constants of the duplicate value filter
// no dependencies; imported by dvf_cmp and duplicate_value_filter
package dvf_pkg;

    localparam int DATA_W        = 32;
    localparam int TOTAL_W       = 6;
    localparam int MAX_ITEMS_DEF = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_OUTER,
        S_GETV,
        S_CMP,
        S_PLACE,
        S_SREAD,
        S_SDATA,
        S_SFLUSH,
        S_SUMMARY
    } t_state;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp_flags;

endpackage

@@ src/dvf_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module dvf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/dvf_cmp.sv @@
// shared compare unit: greater-than and equality of two identifiers
// depends on dvf_pkg
module dvf_cmp (
    input  logic [dvf_pkg::DATA_W-1:0] i_a,
    input  logic [dvf_pkg::DATA_W-1:0] i_b,
    output dvf_pkg::t_cmp_flags        o_flags
);
    import dvf_pkg::*;

    always_comb begin
        o_flags.gt = (i_a > i_b);
        o_flags.eq = (i_a == i_b);
    end

endmodule

@@ src/duplicate_value_filter.sv @@
// top level of the duplicate value filter: sequencer, store and result register
// depends on dvf_pkg, dvf_ram, dvf_cmp
//
// usage
//   s_axis carries one 32-bit identifier per transaction in tdata; tlast marks
//   the last identifier of a set. while loading, s_axis_tready is high and one
//   identifier is taken per cycle; identifiers beyond MAX_ITEMS are dropped and
//   remembered as an overflow.
//   after the tlast transaction, tready drops while the set is insertion sorted
//   in the store and scanned in ascending order. every element whose value
//   occurs more than once goes out on m_axis as its own transaction (tuser 0)
//   when emit_list is 1, then one summary transaction (tuser 1, tlast 1)
//   carries the duplicate total and the overflow flag.
//   sorting and scanning both go through the single store read port and the one
//   shared comparator.
//   a stalled receiver holds the scan at the pending result; the result
//   register keeps the transaction until m_axis_tready is seen.
//   reset: store empty, overflow clear, emit_list = 1, no result pending.
//   i_cfg_we writes emit_list from i_cfg_wdata; write only while idle.
module duplicate_value_filter #(
    parameter int MAX_ITEMS = dvf_pkg::MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: emit_list
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] block_id
    input  logic        s_axis_tlast,   // final_item
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] dup_value, [37:32] dup_total,
                                        // [38] overflowed, [39] zero
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_of_run
);
    import dvf_pkg::*;

    // count width holds MAX_ITEMS itself, address width only the entries
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    // control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_emit_list;
    logic [CW-1:0]      r_i, n_i;       // sort outer index, later scan index
    logic [CW-1:0]      r_j, n_j;       // sort insertion position
    logic [CW-1:0]      r_total, n_total;
    logic               r_have, n_have; // scan holds a current element
    logic               r_eqp, n_eqp;   // current element equals its predecessor

    // payload
    logic [DATA_W-1:0]  r_opnd, n_opnd; // insert value in sort, current element in scan

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [DATA_W-1:0]  r_out_value, n_out_value;
    logic [CW-1:0]      r_out_total, n_out_total;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;

    // store port
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [DATA_W-1:0]  w_wdata, w_rdata;

    t_cmp_flags         w_flags;

    logic               w_s_accept;
    logic               w_can_emit;
    logic               w_dup;
    logic               w_need_emit;
    logic               w_hold;
    logic               w_full;

    dvf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // one comparator: store read data against the operand register
    dvf_cmp u_cmp (
        .i_a     (w_rdata),
        .i_b     (r_opnd),
        .o_flags (w_flags)
    );

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(MAX_ITEMS));

    // result register free now or freed at this edge
    assign w_can_emit = !r_out_valid || m_axis_tready;

    // the current scan element is duplicated if it matches either neighbor;
    // in flush there is no following element
    always_comb begin
        if (r_state == S_SFLUSH) begin
            w_dup = r_have && r_eqp;
        end else begin
            w_dup = r_have && (r_eqp || w_flags.eq);
        end
    end
    assign w_need_emit = w_dup && r_emit_list;
    assign w_hold      = w_need_emit && !w_can_emit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_s_accept && s_axis_tlast) begin
                    n_state = S_OUTER;
                end
            end
            S_OUTER: begin
                if (r_i >= r_count) begin
                    n_state = S_SREAD;
                end else begin
                    n_state = S_GETV;
                end
            end
            S_GETV: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!w_flags.gt || r_j <= CW'(1)) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = S_OUTER;
            end
            S_SREAD: begin
                if (r_i == r_count) begin
                    n_state = S_SFLUSH;
                end else begin
                    n_state = S_SDATA;
                end
            end
            S_SDATA: begin
                if (!w_hold) begin
                    n_state = S_SREAD;
                end
            end
            S_SFLUSH: begin
                if (!w_hold) begin
                    n_state = S_SUMMARY;
                end
            end
            S_SUMMARY: begin
                if (w_can_emit) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // datapath controls and next register values
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_total     = r_total;
        n_have      = r_have;
        n_eqp       = r_eqp;
        n_opnd      = r_opnd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_waddr     = r_j[AW-1:0];
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = r_i[AW-1:0];

        case (r_state)
            S_LOAD: begin
                if (w_s_accept) begin
                    if (!w_full) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        w_wdata = s_axis_tdata;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_i = CW'(1);
                    end
                end
            end
            S_OUTER: begin
                if (r_i >= r_count) begin
                    // sorted; start the scan
                    n_i     = '0;
                    n_total = '0;
                    n_have  = 1'b0;
                    n_eqp   = 1'b0;
                end else begin
                    w_re = 1'b1;
                end
            end
            S_GETV: begin
                n_opnd  = w_rdata;
                n_j     = r_i;
                w_re    = 1'b1;
                w_raddr = AW'(r_i - CW'(1));
            end
            S_CMP: begin
                // shift the larger neighbor up and look one further down
                if (w_flags.gt) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_j     = r_j - CW'(1);
                    if (r_j > CW'(1)) begin
                        w_re    = 1'b1;
                        w_raddr = AW'(r_j - CW'(2));
                    end
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_opnd;
                n_i     = r_i + CW'(1);
            end
            S_SREAD: begin
                if (r_i != r_count) begin
                    w_re = 1'b1;
                    n_i  = r_i + CW'(1);
                end
            end
            S_SDATA, S_SFLUSH: begin
                if (!w_hold) begin
                    if (w_dup) begin
                        n_total = r_total + CW'(1);
                    end
                    if (w_need_emit) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = 1'b0;
                        n_out_value = r_opnd;
                        n_out_total = '0;
                        n_out_ovf   = 1'b0;
                        n_out_last  = 1'b0;
                    end
                    if (r_state == S_SDATA) begin
                        n_opnd = w_rdata;
                        n_eqp  = r_have && w_flags.eq;
                        n_have = 1'b1;
                    end
                end
            end
            S_SUMMARY: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_value = '0;
                    n_out_total = r_total;
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_total     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_emit_list <= 1'b1;
            r_i         <= '0;
            r_j         <= '0;
            r_total     <= '0;
            r_have      <= 1'b0;
            r_eqp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_total     <= n_total;
            r_have      <= n_have;
            r_eqp       <= n_eqp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_emit_list <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd      <= n_opnd;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ovf, TOTAL_W'(r_out_total), r_out_value};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // store fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("stored count beyond store depth");

    // duplicates found never exceed the elements stored
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_count)
        else $error("duplicate total exceeds stored count");

    // the final identifier closes the input until the summary is out
    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after final identifier");

    // issuing the summary empties the store and reopens loading
    a_summary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUMMARY && w_can_emit) |=>
            (r_count == '0 && !r_ovf && r_state == S_LOAD && m_axis_tlast))
        else $error("summary did not clear the set");

    // the sort never writes above the last stored entry
    a_sort_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state != S_LOAD) |-> (r_j < r_count))
        else $error("sort write outside the stored set");

endmodule
